FILE: sv/fap_pkg.sv
// Shared types, fixed-point constants and the coefficient table of the
// fundamental argument pipeline. No dependencies.
package fap_pkg;

  // fixed-point formats
  localparam int T_FRAC_BITS   = 40;
  localparam int OUT_FRAC_BITS = 32;
  localparam int RK            = 40;   // radian coefficient fraction bits
  localparam int AK            = 24;   // arcsecond coefficient fraction bits
  localparam int ACS_FRAC      = 58;
  localparam int SCALE_SHIFT   = AK + ACS_FRAC - OUT_FRAC_BITS;
  localparam int PROD_W        = 112;  // 64 x 48 magnitude product
  localparam int T_W           = 48;
  localparam int ACC_W         = 64;
  localparam int ANGLE_W       = 54;
  localparam int NUM_TERMS     = 5;    // coefficients of T^0..T^4

  localparam logic [63:0] ACS_Q58  = 64'd1397380296697;
  // radian results reuse the arcsecond scaler with a power of two
  localparam logic [T_W-1:0] FAC_LUNI = ACS_Q58[T_W-1:0];
  localparam logic [T_W-1:0] FAC_LIN  = T_W'(1) << (AK + ACS_FRAC - RK);

  // selector codes
  localparam logic [3:0] OP_PREC       = 4'd8;
  localparam logic [3:0] OP_LUNI_FIRST = 4'd9;
  localparam logic [3:0] OP_LUNI_LAST  = 4'd14;
  localparam logic [3:0] OP_INVALID    = 4'd15;

  typedef struct packed {
    logic [3:0]            opcode;
    logic signed [T_W-1:0] t_centuries;
  } fap_req_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_rad;
    logic                      arg_valid;
  } fap_res_t;

  // payload carried between pipeline sections
  typedef struct packed {
    logic [3:0]       op;
    logic [T_W-1:0]   tmag;
    logic             tneg;
    logic [ACC_W-1:0] acc;
  } fap_stage_t;

  // Horner table. Lunisolar rows: index k holds the coefficient of T^k.
  // Planets: constant at index 0, rate at the last. Precession: rate at 1, quadratic term at the last.
  localparam logic [63:0] COEF_ROM [16][NUM_TERMS] = '{
    // Mercury
    '{(64'd4 << RK) + ((64'd402608842 << (RK - 9)) + 64'd1953125 / 2) / 64'd1953125,
      64'd0, 64'd0, 64'd0,
      (64'd2608 << RK)
        + ((64'd7903141574 << (RK - 10)) + 64'd9765625 / 2) / 64'd9765625},
    // Venus
    '{(64'd3 << RK) + ((64'd176146697 << (RK - 9)) + 64'd1953125 / 2) / 64'd1953125,
      64'd0, 64'd0, 64'd0,
      (64'd1021 << RK)
        + ((64'd3285546211 << (RK - 10)) + 64'd9765625 / 2) / 64'd9765625},
    // Earth
    '{(64'd1 << RK) + ((64'd753470314 << (RK - 9)) + 64'd1953125 / 2) / 64'd1953125,
      64'd0, 64'd0, 64'd0,
      (64'd628 << RK)
        + ((64'd3075849991 << (RK - 10)) + 64'd9765625 / 2) / 64'd9765625},
    // Mars
    '{(64'd6 << RK) + ((64'd203480913 << (RK - 9)) + 64'd1953125 / 2) / 64'd1953125,
      64'd0, 64'd0, 64'd0,
      (64'd334 << RK)
        + ((64'd612426700 << (RK - 10)) + 64'd9765625 / 2) / 64'd9765625},
    // Jupiter
    '{(64'd0 << RK) + ((64'd599546497 << (RK - 9)) + 64'd1953125 / 2) / 64'd1953125,
      64'd0, 64'd0, 64'd0,
      (64'd52 << RK)
        + ((64'd9690962641 << (RK - 10)) + 64'd9765625 / 2) / 64'd9765625},
    // Saturn
    '{(64'd0 << RK) + ((64'd874016757 << (RK - 9)) + 64'd1953125 / 2) / 64'd1953125,
      64'd0, 64'd0, 64'd0,
      (64'd21 << RK)
        + ((64'd3299104960 << (RK - 10)) + 64'd9765625 / 2) / 64'd9765625},
    // Uranus
    '{(64'd5 << RK) + ((64'd481293872 << (RK - 9)) + 64'd1953125 / 2) / 64'd1953125,
      64'd0, 64'd0, 64'd0,
      (64'd7 << RK)
        + ((64'd4781598567 << (RK - 10)) + 64'd9765625 / 2) / 64'd9765625},
    // Neptune
    '{(64'd5 << RK) + ((64'd311886287 << (RK - 9)) + 64'd1953125 / 2) / 64'd1953125,
      64'd0, 64'd0, 64'd0,
      (64'd3 << RK)
        + ((64'd8133035638 << (RK - 10)) + 64'd9765625 / 2) / 64'd9765625},
    // general precession
    '{64'd0,
      ((64'd24381750 << (RK - 9)) + 64'd1953125 / 2) / 64'd1953125,
      64'd0, 64'd0,
      ((64'd538691 << (RK - 11)) + 64'd48828125 / 2) / 64'd48828125},
    // l
    '{(64'd485868 << AK) + ((64'd249036 << (AK - 6)) + 64'd15625 / 2) / 64'd15625,
      (64'd1717915923 << AK) + ((64'd2178 << (AK - 4)) + 64'd625 / 2) / 64'd625,
      (64'd31 << AK) + ((64'd8792 << (AK - 4)) + 64'd625 / 2) / 64'd625,
      ((64'd51635 << (AK - 6)) + 64'd15625 / 2) / 64'd15625,
      64'd0 - ((64'd24470 << (AK - 8)) + 64'd390625 / 2) / 64'd390625},
    // l'
    '{(64'd1287104 << AK) + ((64'd79305 << (AK - 5)) + 64'd3125 / 2) / 64'd3125,
      (64'd129596581 << AK) + ((64'd481 << (AK - 4)) + 64'd625 / 2) / 64'd625,
      64'd0 - ((64'd5532 << (AK - 4)) + 64'd625 / 2) / 64'd625,
      ((64'd136 << (AK - 6)) + 64'd15625 / 2) / 64'd15625,
      64'd0 - ((64'd1149 << (AK - 8)) + 64'd390625 / 2) / 64'd390625},
    // F
    '{(64'd335779 << AK) + ((64'd526232 << (AK - 6)) + 64'd15625 / 2) / 64'd15625,
      (64'd1739527262 << AK) + ((64'd8478 << (AK - 4)) + 64'd625 / 2) / 64'd625,
      64'd0 - ((64'd12 << AK) + ((64'd7512 << (AK - 4)) + 64'd625 / 2) / 64'd625),
      64'd0 - ((64'd1037 << (AK - 6)) + 64'd15625 / 2) / 64'd15625,
      ((64'd417 << (AK - 8)) + 64'd390625 / 2) / 64'd390625},
    // D
    '{(64'd1072260 << AK) + ((64'd70369 << (AK - 5)) + 64'd3125 / 2) / 64'd3125,
      (64'd1602961601 << AK) + ((64'd2090 << (AK - 4)) + 64'd625 / 2) / 64'd625,
      64'd0 - ((64'd6 << AK) + ((64'd3706 << (AK - 4)) + 64'd625 / 2) / 64'd625),
      ((64'd6593 << (AK - 6)) + 64'd15625 / 2) / 64'd15625,
      64'd0 - ((64'd3169 << (AK - 8)) + 64'd390625 / 2) / 64'd390625},
    // Omega
    '{(64'd450160 << AK) + ((64'd398036 << (AK - 6)) + 64'd15625 / 2) / 64'd15625,
      64'd0 - ((64'd6962890 << AK) + ((64'd5431 << (AK - 4)) + 64'd625 / 2) / 64'd625),
      (64'd7 << AK) + ((64'd4722 << (AK - 4)) + 64'd625 / 2) / 64'd625,
      ((64'd7702 << (AK - 6)) + 64'd15625 / 2) / 64'd15625,
      64'd0 - ((64'd5939 << (AK - 8)) + 64'd390625 / 2) / 64'd390625},
    // lunar mean longitude
    '{(64'd785939 << AK) + ((64'd95571 << (AK - 5)) + 64'd3125 / 2) / 64'd3125,
      (64'd1732559343 << AK) + ((64'd73604 << (AK - 5)) + 64'd3125 / 2) / 64'd3125,
      64'd0 - ((64'd5 << AK) + ((64'd8883 << (AK - 4)) + 64'd625 / 2) / 64'd625),
      ((64'd6604 << (AK - 6)) + 64'd15625 / 2) / 64'd15625,
      64'd0 - ((64'd3169 << (AK - 8)) + 64'd390625 / 2) / 64'd390625},
    // invalid selector
    '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0}
  };

  function automatic logic fap_is_luni(input logic [3:0] op);
    return (op >= OP_LUNI_FIRST) && (op <= OP_LUNI_LAST);
  endfunction

  // whether Horner step k does work for this selector; else acc passes
  function automatic logic fap_step_on(input logic [3:0] op, input logic [2:0] k);
    logic on;
    on = 1'b0;
    if (fap_is_luni(op))
      on = 1'b1;
    else if (op == OP_PREC)
      on = (k <= 3'd1);
    else if (op < OP_PREC)
      on = (k == 3'd0);
    return on;
  endfunction

endpackage

FILE: sv/fap_mul.sv
// Two-stage 64 x 48 unsigned multiply-add built from 32-bit partial products.
// Depends on fap_pkg.
module fap_mul import fap_pkg::*; (
  input  logic                 clk,
  input  logic [ACC_W-1:0]     a,
  input  logic [T_W-1:0]       b,
  input  logic [PROD_W-1:0]    addend,
  output logic [PROD_W-1:0]    prod
);

  logic [63:0]        p00_r, p10_r;
  logic [47:0]        p01_r, p11_r;
  logic [PROD_W-1:0]  add_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  prod_nxt;

  always_ff @(posedge clk) begin
    p00_r <= 64'(a[31:0])  * 64'(b[31:0]);
    p01_r <= 48'(a[31:0])  * 48'(b[47:32]);
    p10_r <= 64'(a[63:32]) * 64'(b[31:0]);
    p11_r <= 48'(a[63:32]) * 48'(b[47:32]);
    add_r <= addend;
  end

  assign prod_nxt = {48'd0, p00_r}
                  + {32'd0, p01_r, 32'd0}
                  + {16'd0, p10_r, 32'd0}
                  + {p11_r, 64'd0}
                  + add_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

FILE: sv/fap_step.sv
// One Horner step: acc = coef[k] + round(acc * T >> T_FRAC_BITS), saturated, or acc passed through.
// Four register stages. Depends on fap_pkg and fap_mul.
module fap_step import fap_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] step_idx,
  input  logic       in_vld,
  input  fap_stage_t in_stg,
  output logic       out_vld,
  output fap_stage_t out_stg
);

  localparam int QW = PROD_W - T_FRAC_BITS;
  localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (T_FRAC_BITS - 1);

  logic             s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  fap_stage_t       s1_r, s2_r, s3_r, s4_r;
  fap_stage_t       s4_nxt;
  logic             s1_neg_r, s2_neg_r, s3_neg_r;
  logic [ACC_W-1:0] s1_amag_r;
  logic [PROD_W-1:0] prod;
  logic [QW-1:0]    q;
  logic [62:0]      mag;
  logic [63:0]      coef;
  logic [64:0]      sum;
  logic [63:0]      sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  // magnitude and product sign
  always_ff @(posedge clk) begin
    s1_r      <= in_stg;
    s1_amag_r <= in_stg.acc[63] ? (64'd0 - in_stg.acc) : in_stg.acc;
    s1_neg_r  <= in_stg.acc[63] ^ in_stg.tneg;
    s2_r      <= s1_r;
    s2_neg_r  <= s1_neg_r;
    s3_r      <= s2_r;
    s3_neg_r  <= s2_neg_r;
  end

  fap_mul u_mul (
    .clk    (clk),
    .a      (s1_amag_r),
    .b      (s1_r.tmag),
    .addend (RND),
    .prod   (prod)
  );

  // shift, saturate the magnitude, then signed add with saturation
  always_comb begin
    q    = prod[PROD_W-1:T_FRAC_BITS];
    mag  = (|q[QW-1:63]) ? '1 : q[62:0];
    coef = COEF_ROM[s3_r.op][step_idx];
    if (s3_neg_r)
      sum = {coef[63], coef} - {2'b00, mag};
    else
      sum = {coef[63], coef} + {2'b00, mag};
    if (sum[64] != sum[63])
      sat = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else
      sat = sum[63:0];
    s4_nxt     = s3_r;
    s4_nxt.acc = fap_step_on(s3_r.op, step_idx) ? sat : s3_r.acc;
  end

  always_ff @(posedge clk) begin
    s4_r <= s4_nxt;
  end

  assign out_vld = s4_vld_r;
  assign out_stg = s4_r;

endmodule

FILE: sv/fap_scale.sv
// Final scaling to radians with rounding and clamping to the 54-bit result,
// plus the invalid-selector case. Four register stages. Depends on fap_pkg, fap_mul.
module fap_scale import fap_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_vld,
  input  fap_stage_t in_stg,
  output logic       out_vld,
  output fap_res_t   out_res
);

  localparam int QW = PROD_W - SCALE_SHIFT;
  localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (SCALE_SHIFT - 1);
  localparam logic [QW-1:0] LIM_POS = (QW'(1) << (ANGLE_W - 1)) - QW'(1);
  localparam logic [QW-1:0] LIM_NEG = QW'(1) << (ANGLE_W - 1);

  logic             s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic [3:0]       s1_op_r, s2_op_r, s3_op_r;
  logic             s1_neg_r, s2_neg_r, s3_neg_r;
  logic [ACC_W-1:0] s1_amag_r;
  logic [T_W-1:0]   s1_fac_r;
  logic [PROD_W-1:0] prod;
  logic [QW-1:0]    q;
  logic [QW-1:0]    lim;
  logic [ANGLE_W-1:0] mag;
  fap_res_t         res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r   <= in_stg.op;
    s1_neg_r  <= in_stg.acc[63];
    s1_amag_r <= in_stg.acc[63] ? (64'd0 - in_stg.acc) : in_stg.acc;
    s1_fac_r  <= fap_is_luni(in_stg.op) ? FAC_LUNI : FAC_LIN;
    s2_op_r   <= s1_op_r;
    s2_neg_r  <= s1_neg_r;
    s3_op_r   <= s2_op_r;
    s3_neg_r  <= s2_neg_r;
  end

  fap_mul u_mul (
    .clk    (clk),
    .a      (s1_amag_r),
    .b      (s1_fac_r),
    .addend (RND),
    .prod   (prod)
  );

  always_comb begin
    q   = prod[PROD_W-1:SCALE_SHIFT];
    lim = s3_neg_r ? LIM_NEG : LIM_POS;
    mag = (q > lim) ? lim[ANGLE_W-1:0] : q[ANGLE_W-1:0];
    if (s3_op_r == OP_INVALID) begin
      res_nxt.angle_rad = ANGLE_W'(0) - (ANGLE_W'(1) << OUT_FRAC_BITS);
      res_nxt.arg_valid = 1'b0;
    end else begin
      res_nxt.angle_rad = s3_neg_r ? (ANGLE_W'(0) - mag) : mag;
      res_nxt.arg_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_vld = s4_vld_r;
  assign out_res = res_r;

endmodule

FILE: sv/fundamental_argument_poly.sv
// Top level of the fundamental argument pipeline (planetary, precession and
// lunisolar arguments). Depends on fap_pkg, fap_step and fap_scale.
//
//   channel  ports                  handshake
//   -------  ---------------------  -----------------------------------------
//   request  start, busy, in_req    taken at a rising edge with start && !busy
//   result   out_valid, out_res     one-cycle strobe, cannot be held off
//
// One request per clock cycle, sustained: busy is always low. Each request
// crosses an entry register, four Horner step sections of four stages each
// (abs, two multiplier stages, round/saturate/add) and a four-stage scaling
// section, so its result strobes on out_valid in request order.
// Reset (synchronous, active low) clears only the valid bits in flight.
// Nothing stalls: every stage advances every cycle.
module fundamental_argument_poly import fap_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  fap_req_t in_req,
  output logic     out_valid,
  output fap_res_t out_res
);

  logic       accept;
  logic       s0_vld_r;
  fap_stage_t s0_r, s0_nxt;

  logic       v3, v2, v1, v0;
  fap_stage_t g3, g2, g1, g0;

  // the pipeline never backs up, so requests are always welcome
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // entry: split T into sign and magnitude, load the highest coefficient
  always_comb begin
    s0_nxt.op   = in_req.opcode;
    s0_nxt.tneg = in_req.t_centuries[T_W-1];
    s0_nxt.tmag = in_req.t_centuries[T_W-1] ? (T_W'(0) - in_req.t_centuries)
                                            : in_req.t_centuries;
    s0_nxt.acc  = COEF_ROM[in_req.opcode][NUM_TERMS-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
  end

  // Horner chain, highest power first; steps a selector does not use pass acc
  fap_step u_step3 (
    .clk (clk), .rst_n (rst_n), .step_idx (3'd3),
    .in_vld (s0_vld_r), .in_stg (s0_r), .out_vld (v3), .out_stg (g3)
  );

  fap_step u_step2 (
    .clk (clk), .rst_n (rst_n), .step_idx (3'd2),
    .in_vld (v3), .in_stg (g3), .out_vld (v2), .out_stg (g2)
  );

  fap_step u_step1 (
    .clk (clk), .rst_n (rst_n), .step_idx (3'd1),
    .in_vld (v2), .in_stg (g2), .out_vld (v1), .out_stg (g1)
  );

  fap_step u_step0 (
    .clk (clk), .rst_n (rst_n), .step_idx (3'd0),
    .in_vld (v1), .in_stg (g1), .out_vld (v0), .out_stg (g0)
  );

  // radians: arcseconds times pi/648000, or a plain rounding shift
  fap_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v0),
    .in_stg  (g0),
    .out_vld (out_valid),
    .out_res (out_res)
  );

endmodule
